FILE: design/xxl_pkg.sv
package xxl_pkg;

  // input kinds carried on tuser
  typedef enum logic [1:0] {
    CMD_TX    = 2'd0,
    CMD_RX    = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_t;

  // result destinations carried on tuser
  typedef enum logic [1:0] {
    DEST_CHANNEL = 2'd0,
    DEST_LOCAL   = 2'd1,
    DEST_REFUSED = 2'd2
  } dest_t;

  // configuration register indexes
  localparam logic [1:0] REG_XON_CHAR    = 2'd0;
  localparam logic [1:0] REG_XOFF_CHAR   = 2'd1;
  localparam logic [1:0] REG_ESCAPE_CHAR = 2'd2;
  localparam logic [1:0] REG_ESCAPE_MASK = 2'd3;

  localparam logic [7:0] XON_RESET    = 8'd17;
  localparam logic [7:0] XOFF_RESET   = 8'd19;
  localparam logic [7:0] ESCAPE_RESET = 8'd127;
  localparam logic [7:0] MASK_RESET   = 8'd32;

  typedef struct packed {
    dest_t      dest;
    logic [7:0] data;
  } res_t;

  // up to two results produced by one input transfer
  typedef struct packed {
    logic       push;
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } batch_t;

endpackage

FILE: design/xon_xoff_escaped_link.sv
// XON/XOFF flow-controlled, byte-stuffed serial link, channel side.
// Input stream (s_axis_*): tuser = command (0 transmit, 1 received from
// channel, 2 receive buffer drained); tdata = data_byte, rx_level_high.
// Output stream (m_axis_*): tuser = destination (0 to channel, 1 local,
// 2 transmit refused); tdata = out_byte; tlast marks the final result of
// each input transfer. Inputs that give no result produce no transfer.
// Each input yields zero, one or two results, computed in the accept cycle
// and registered in a two-entry result buffer; the first result appears
// in the cycle after the input transfer.
// With m_axis ready: one input per cycle if it has at most one result, and
// after a two-result input (escaped transmit, delivered byte plus XOFF)
// the next waits on its first result; buffer drains one result per cycle.
// A stall on m_axis holds the buffer and s_axis_tready drops until the
// last buffered result is taken. Reset (rst, synchronous) empties the
// buffer, clears the stopped/escape/XOFF state and restores the registers
// xon_char, xoff_char, escape_char, escape_mask (index 0..3) to defaults.
module xon_xoff_escaped_link (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] rx_level_high
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] destination
  output logic        m_axis_tlast
);
  import xxl_pkg::*;

  logic   accept;
  batch_t batch;
  res_t   out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  xxl_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .command       (s_axis_tuser),
    .data_byte     (s_axis_tdata[7:0]),
    .rx_level_high (s_axis_tdata[8]),
    .batch         (batch)
  );

  xxl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .batch     (batch),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.dest;

endmodule

FILE: design/xxl_engine.sv
module xxl_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               accept,
  input  logic [1:0]         command,
  input  logic [7:0]         data_byte,
  input  logic               rx_level_high,
  output xxl_pkg::batch_t    batch
);
  import xxl_pkg::*;

  logic [7:0] xon_char;
  logic [7:0] xoff_char;
  logic [7:0] escape_char;
  logic [7:0] escape_mask;

  logic peer_stopped, peer_stopped_next;
  logic escape_pending, escape_pending_next;
  logic xoff_sent, xoff_sent_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      xon_char    <= XON_RESET;
      xoff_char   <= XOFF_RESET;
      escape_char <= ESCAPE_RESET;
      escape_mask <= MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XON_CHAR:    xon_char    <= cfg_data;
        REG_XOFF_CHAR:   xoff_char   <= cfg_data;
        REG_ESCAPE_CHAR: escape_char <= cfg_data;
        REG_ESCAPE_MASK: escape_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_stopped   <= 1'b0;
      escape_pending <= 1'b0;
      xoff_sent      <= 1'b0;
    end else if (accept) begin
      peer_stopped   <= peer_stopped_next;
      escape_pending <= escape_pending_next;
      xoff_sent      <= xoff_sent_next;
    end
  end

  logic       special;
  logic       has_local;
  logic       xoff_now;
  logic [7:0] masked;

  assign masked  = data_byte ^ escape_mask;
  assign special = (data_byte == xon_char) || (data_byte == xoff_char) ||
                   (data_byte == escape_char);

  always_comb begin
    peer_stopped_next   = peer_stopped;
    escape_pending_next = escape_pending;
    xoff_sent_next      = xoff_sent;
    has_local           = 1'b0;
    xoff_now            = 1'b0;
    batch.push          = accept;
    batch.count         = 2'd0;
    batch.r0            = '{dest: DEST_CHANNEL, data: data_byte};
    batch.r1            = '{dest: DEST_CHANNEL, data: masked};
    case (command)
      CMD_TX: begin
        if (peer_stopped) begin
          batch.count = 2'd1;
          batch.r0    = '{dest: DEST_REFUSED, data: data_byte};
        end else if (special) begin
          batch.count = 2'd2;
          batch.r0    = '{dest: DEST_CHANNEL, data: escape_char};
        end else begin
          batch.count = 2'd1;
        end
      end
      CMD_RX: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          has_local           = 1'b1;
          batch.r0            = '{dest: DEST_LOCAL, data: masked};
        end else if (data_byte == escape_char) begin
          escape_pending_next = 1'b1;
        end else if (data_byte == xoff_char) begin
          peer_stopped_next = 1'b1;
        end else if (data_byte == xon_char) begin
          peer_stopped_next = 1'b0;
        end else begin
          has_local = 1'b1;
          batch.r0  = '{dest: DEST_LOCAL, data: data_byte};
        end
        // an escape byte skips the high-water check
        xoff_now = rx_level_high && !xoff_sent &&
                   (escape_pending || (data_byte != escape_char));
        if (xoff_now) begin
          xoff_sent_next = 1'b1;
        end
        if (has_local) begin
          batch.r1 = '{dest: DEST_CHANNEL, data: xoff_char};
        end else begin
          batch.r0 = '{dest: DEST_CHANNEL, data: xoff_char};
        end
        batch.count = {1'b0, has_local} + {1'b0, xoff_now};
      end
      CMD_DRAIN: begin
        if (xoff_sent) begin
          xoff_sent_next = 1'b0;
          batch.count    = 2'd1;
          batch.r0       = '{dest: DEST_CHANNEL, data: xon_char};
        end
      end
      default: ;
    endcase
  end

  a_pending_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_RX && escape_pending) |=> !escape_pending)
    else $error("escape_pending not cleared after escaped byte");

  a_xoff_once: assert property (@(posedge clk) disable iff (rst)
    (accept && xoff_now) |-> !xoff_sent)
    else $error("XOFF sent twice without XON");

  a_refused_only_stopped: assert property (@(posedge clk) disable iff (rst)
    (accept && batch.count != 2'd0 && batch.r0.dest == DEST_REFUSED) |-> peer_stopped)
    else $error("transmit refused while peer not stopped");

endmodule

FILE: design/xxl_out_buf.sv
module xxl_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  xxl_pkg::batch_t    batch,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output xxl_pkg::res_t      out_res,
  output logic               out_last
);
  import xxl_pkg::*;

  logic [1:0] cnt;
  res_t       slot0;
  res_t       slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_res   = slot0;
  assign out_last  = (cnt == 2'd1);
  // take a new batch when the buffer is empty or its last entry leaves now
  assign in_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (batch.push) begin
      cnt <= batch.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (batch.push) begin
      slot0 <= batch.r0;
      slot1 <= batch.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    batch.push |-> (cnt == 2'd0) || (cnt == 2'd1 && pop))
    else $error("batch pushed over pending results");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && pop) |=> (cnt == 2'd1) && (slot0 == $past(slot1)))
    else $error("second result not advanced");

endmodule
